### design/rgbg_pkg.sv
package rgbg_pkg;

   localparam int unsigned COORD_W = 10;

   localparam logic [6:0] LUMA_R_COEF = 7'd77;
   localparam logic [7:0] LUMA_G_COEF = 8'd150;
   localparam logic [4:0] LUMA_B_COEF = 5'd29;
   localparam logic [15:0] LUMA_ROUND = 16'd128;

   localparam logic [7:0] LUMA_BLACK = 8'd0;
   localparam logic [7:0] LUMA_WHITE = 8'd255;
   localparam logic [8:0] PLAIN_BIAS = 9'd8;

   // 241 / 4096 is 1/17 scaled up by 4097/4096, exact for values below 4096 / 17 * 17.
   localparam logic [16:0] DIV17_RECIP = 17'd241;
   localparam int unsigned DIV17_SHIFT = 12;
   localparam logic [4:0] LEVEL_MAX = 5'd15;

   typedef logic [7:0] expand5_type [32];
   typedef logic [7:0] expand6_type [64];
   typedef logic [3:0] bayer_type [16];

   function automatic expand5_type build_expand5();
      expand5_type t;
      for (int i = 0; i < 32; i++) begin
         t[i] = 8'(i * 255 / 31);
      end
      return t;
   endfunction

   function automatic expand6_type build_expand6();
      expand6_type t;
      for (int i = 0; i < 64; i++) begin
         t[i] = 8'(i * 255 / 63);
      end
      return t;
   endfunction

   localparam expand5_type EXPAND5_TABLE = build_expand5();
   localparam expand6_type EXPAND6_TABLE = build_expand6();

   // Indexed by {row[1:0], column[1:0]}.
   localparam bayer_type BAYER_TABLE = '{
      4'd0,  4'd8,  4'd2,  4'd10,
      4'd12, 4'd4,  4'd14, 4'd6,
      4'd3,  4'd11, 4'd1,  4'd9,
      4'd15, 4'd7,  4'd13, 4'd5
   };

   typedef struct packed {
      logic [15:0]        pixel_rgb565;
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
   } pixel_type;

   typedef struct packed {
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
   } rgb8_type;

   typedef struct packed {
      logic [14:0]        red_prod;
      logic [15:0]        green_prod;
      logic [12:0]        blue_prod;
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
   } prod_type;

   typedef struct packed {
      logic [7:0]         luma;
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
   } luma_type;

   typedef struct packed {
      logic [8:0]         biased;
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
   } biased_type;

   typedef struct packed {
      logic [3:0]         gray_level;
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
   } result_type;

endpackage

### design/rgbg_expand.sv
module rgbg_expand
   import rgbg_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  pixel_type in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output rgb8_type  out_data
);

   logic     valid_ff;
   rgb8_type data_ff;
   rgb8_type data_in;

   assign in_ready = ~valid_ff | out_ready;

   always_comb begin
      data_in.red    = EXPAND5_TABLE[in_data.pixel_rgb565[15:11]];
      data_in.green  = EXPAND6_TABLE[in_data.pixel_rgb565[10:5]];
      data_in.blue   = EXPAND5_TABLE[in_data.pixel_rgb565[4:0]];
      data_in.column = in_data.column;
      data_in.row    = in_data.row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### design/rgbg_luma.sv
module rgbg_luma
   import rgbg_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  rgb8_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output luma_type out_data
);

   logic        prod_valid_ff;
   prod_type    prod_ff;
   prod_type    prod_in;
   logic        prod_ready;
   logic        luma_valid_ff;
   luma_type    luma_ff;
   luma_type    luma_in;
   logic [15:0] sum;

   assign prod_ready = ~luma_valid_ff | out_ready;
   assign in_ready   = ~prod_valid_ff | prod_ready;

   always_comb begin
      prod_in.red_prod   = 15'(in_data.red) * 15'(LUMA_R_COEF);
      prod_in.green_prod = 16'(in_data.green) * 16'(LUMA_G_COEF);
      prod_in.blue_prod  = 13'(in_data.blue) * 13'(LUMA_B_COEF);
      prod_in.column     = in_data.column;
      prod_in.row        = in_data.row;
   end

   always_comb begin
      sum = 16'(prod_ff.red_prod) + prod_ff.green_prod + 16'(prod_ff.blue_prod)
            + LUMA_ROUND;
      luma_in.luma   = sum[15:8];
      luma_in.column = prod_ff.column;
      luma_in.row    = prod_ff.row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         luma_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            prod_valid_ff <= in_valid;
         end
         if (prod_ready) begin
            luma_valid_ff <= prod_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         prod_ff <= prod_in;
      end
      if (prod_ready && prod_valid_ff) begin
         luma_ff <= luma_in;
      end
   end

   assign out_valid = luma_valid_ff;
   assign out_data  = luma_ff;

endmodule

### design/rgbg_quant.sv
module rgbg_quant
   import rgbg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       dither_enable,
   input  logic       in_valid,
   output logic       in_ready,
   input  luma_type   in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic        bias_valid_ff;
   biased_type  bias_ff;
   biased_type  bias_in;
   logic        bias_ready;
   logic        level_valid_ff;
   result_type  level_ff;
   result_type  level_in;
   logic [3:0]  bayer;
   logic [16:0] scaled;
   logic [4:0]  quotient;

   assign bias_ready = ~level_valid_ff | out_ready;
   assign in_ready   = ~bias_valid_ff | bias_ready;

   always_comb begin
      bayer = BAYER_TABLE[{in_data.row[1:0], in_data.column[1:0]}];
      if (dither_enable && in_data.luma != LUMA_BLACK && in_data.luma != LUMA_WHITE) begin
         bias_in.biased = {1'b0, in_data.luma} + {5'b0, bayer};
      end else begin
         bias_in.biased = {1'b0, in_data.luma} + PLAIN_BIAS;
      end
      bias_in.column = in_data.column;
      bias_in.row    = in_data.row;
   end

   always_comb begin
      scaled   = 17'(bias_ff.biased) * DIV17_RECIP;
      quotient = scaled[DIV17_SHIFT +: 5];
      if (quotient > LEVEL_MAX) begin
         level_in.gray_level = LEVEL_MAX[3:0];
      end else begin
         level_in.gray_level = quotient[3:0];
      end
      level_in.column = bias_ff.column;
      level_in.row    = bias_ff.row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_valid_ff  <= 1'b0;
         level_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            bias_valid_ff <= in_valid;
         end
         if (bias_ready) begin
            level_valid_ff <= bias_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         bias_ff <= bias_in;
      end
      if (bias_ready && bias_valid_ff) begin
         level_ff <= level_in;
      end
   end

   assign out_valid = level_valid_ff;
   assign out_data  = level_ff;

endmodule

### design/rgb565_to_gray4_bayer_dither_top.sv
// RGB565 to 4-bit gray converter with 4x4 ordered dither.
// The req channel carries one pixel per beat: its RGB565 color and its column
// and row. The rsp channel returns one beat per pixel with the 4-bit gray level
// and the same column and row, in the order the pixels arrived.
// The csr port writes the dither enable bit; it should only be written while
// no pixels are in flight.
// The datapath is five register stages: channel expansion, luma products, luma
// sum, dither add, and the divide by 17 with clamp, the last of which is the
// output register. A new pixel is accepted every cycle while the rsp receiver
// is ready.
// Each stage has its own valid bit and takes a new beat when it is empty or
// when the stage after it moves, so a stalled receiver fills the stages one by
// one and req_tready drops only once all five hold a pixel.
// Reset empties all stages and sets dither enable to one.
module rgb565_to_gray4_bayer_dither_top
   import rgbg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // pixel_rgb565[15:0], column[25:16], row[35:26]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // gray_level[3:0], out_column[13:4], out_row[23:14]
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   logic       dither_enable_ff;
   pixel_type  pixel;
   logic       rgb_valid;
   logic       rgb_ready;
   rgb8_type   rgb_data;
   logic       luma_valid;
   logic       luma_ready;
   luma_type   luma_data;
   result_type result;

   always_ff @(posedge clock) begin
      if (reset) begin
         dither_enable_ff <= 1'b1;
      end else if (csr_wr_en) begin
         dither_enable_ff <= csr_wr_data;
      end
   end

   assign pixel.pixel_rgb565 = req_tdata[15:0];
   assign pixel.column       = req_tdata[25:16];
   assign pixel.row          = req_tdata[35:26];

   rgbg_expand u_expand (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (pixel),
      .out_valid (rgb_valid),
      .out_ready (rgb_ready),
      .out_data  (rgb_data)
   );

   rgbg_luma u_luma (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rgb_valid),
      .in_ready  (rgb_ready),
      .in_data   (rgb_data),
      .out_valid (luma_valid),
      .out_ready (luma_ready),
      .out_data  (luma_data)
   );

   rgbg_quant u_quant (
      .clock         (clock),
      .reset         (reset),
      .dither_enable (dither_enable_ff),
      .in_valid      (luma_valid),
      .in_ready      (luma_ready),
      .in_data       (luma_data),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_data      (result)
   );

   assign rsp_tdata = {result.row, result.column, result.gray_level};

endmodule

### design/rgbg_checker.sv
module rgbg_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [39:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   logic req_beat;

   assign req_beat = req_tvalid & req_tready;

   // A pixel accepted with the receiver ready from then on has passed every stage
   // and is now at the output.
   property p_flow_through;
      @(posedge clock) disable iff (reset)
         ($past(req_beat, 5) && $past(rsp_tready, 1) && $past(rsp_tready, 2)
          && $past(rsp_tready, 3) && $past(rsp_tready, 4) && !$past(reset, 1)
          && !$past(reset, 2) && !$past(reset, 3) && !$past(reset, 4)
          && !$past(reset, 5))
         |-> rsp_tvalid && rsp_tdata[13:4] == $past(req_tdata[25:16], 5)
             && rsp_tdata[23:14] == $past(req_tdata[35:26], 5);
   endproperty

   // Solid white is never dithered and always maps to the top level.
   property p_white_level;
      @(posedge clock) disable iff (reset)
         ($past(req_beat, 5) && $past(req_tdata[15:0], 5) == 16'hFFFF
          && $past(rsp_tready, 1) && $past(rsp_tready, 2) && $past(rsp_tready, 3)
          && $past(rsp_tready, 4) && !$past(reset, 1) && !$past(reset, 2)
          && !$past(reset, 3) && !$past(reset, 4) && !$past(reset, 5))
         |-> rsp_tdata[3:0] == 4'd15;
   endproperty

   property p_reset_empties;
      @(posedge clock) reset |=> !rsp_tvalid;
   endproperty

   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata);
   endproperty

   a_flow_through: assert property (p_flow_through)
      else $error("pixel did not reach the output after five free cycles");
   a_white_level: assert property (p_white_level)
      else $error("solid white pixel did not give level 15");
   a_reset_empties: assert property (p_reset_empties)
      else $error("output valid right after reset");
   a_rsp_hold: assert property (p_rsp_hold)
      else $error("stalled output beat changed");

endmodule

bind rgb565_to_gray4_bayer_dither_top rgbg_checker u_rgbg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
